@@ rtl/core/generational_slot_allocator_defines.svh @@
// Assertion macros shared by the slot allocator RTL.
// No dependencies; included by modules that carry assertions.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/gsa_pkg.sv @@
// Shared constants, request codes and controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gsa_pkg;

    localparam int SLOTS  = 1024;
    localparam int IDX_W  = 10;
    localparam int LINK_W = 11;
    localparam int GEN_W  = 8;
    localparam int ACT_W  = 11;
    localparam int MODE_W = 2;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 24;

    localparam logic [ACT_W-1:0]  ACTIVE_RST = 11'd1024;
    localparam logic [LINK_W-1:0] SLOTS_END  = 11'd1024;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;

    typedef struct packed {
        logic load;   // capture request, issue table read
        logic exec;   // apply update, load result register
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

@@ rtl/core/gsa_ctrl.sv @@
// Request sequencer for the slot allocator: read phase, then update phase.
// Depends on gsa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "generational_slot_allocator_defines.svh"
module gsa_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    input  wire gsa_pkg::t_status i_status,
    output gsa_pkg::t_cmd        o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `GSA_ASSERT_NEXT(a_load_then_busy, i_clk, i_rst_n, o_cmd.load, !o_req_ready, "ready after load")
    `GSA_ASSERT_NOW(a_cmd_exclusive, i_clk, i_rst_n, o_cmd.exec, !o_cmd.load && !o_req_ready, "exec overlaps load")
    `GSA_ASSERT_NEXT(a_exec_frees, i_clk, i_rst_n, o_cmd.exec, o_req_ready, "not idle after exec")

endmodule
`default_nettype wire

@@ rtl/core/gsa_datapath.sv @@
// Slot allocator datapath: link and stamp tables, free-list head, generation
// counter, fill count and result register. Depends on gsa_pkg and macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "generational_slot_allocator_defines.svh"
module gsa_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire gsa_pkg::t_cmd                i_cmd,
    output gsa_pkg::t_status                  o_status,
    input  wire logic [gsa_pkg::IN_W-1:0]     i_req_data,
    input  wire logic                         i_cfg_we,
    input  wire logic [gsa_pkg::ACT_W-1:0]    i_cfg_wdata,
    output logic                              o_rsp_valid,
    input  wire logic                         i_rsp_ready,
    output logic [gsa_pkg::OUT_W-1:0]         o_rsp_data
);

    logic [gsa_pkg::LINK_W-1:0] r_link_mem  [gsa_pkg::SLOTS];
    logic [gsa_pkg::GEN_W-1:0]  r_stamp_mem [gsa_pkg::SLOTS];

    logic [gsa_pkg::LINK_W-1:0] r_link_q;
    logic [gsa_pkg::GEN_W-1:0]  r_stamp_q;
    logic [gsa_pkg::MODE_W-1:0] r_mode;
    logic [gsa_pkg::IDX_W-1:0]  r_addr;
    logic [gsa_pkg::GEN_W-1:0]  r_gen;

    logic [gsa_pkg::LINK_W-1:0] r_head,    n_head;
    logic [gsa_pkg::GEN_W-1:0]  r_gen_ctr, n_gen_ctr;
    logic [gsa_pkg::LINK_W-1:0] r_fill,    n_fill;
    logic [gsa_pkg::ACT_W-1:0]  r_active;
    logic                       r_out_valid;
    logic [gsa_pkg::OUT_W-1:0]  r_out_data;

    logic [gsa_pkg::MODE_W-1:0] req_mode;
    logic [gsa_pkg::IDX_W-1:0]  req_idx;
    logic [gsa_pkg::GEN_W-1:0]  req_gen;
    logic [gsa_pkg::IDX_W-1:0]  rd_addr;

    logic [gsa_pkg::LINK_W-1:0] slot_ext;
    logic                       untouched;
    logic [gsa_pkg::LINK_W-1:0] link_val;
    logic [gsa_pkg::GEN_W-1:0]  stamp_val;
    logic                       head_usable;
    logic                       handle_ok;
    logic [gsa_pkg::GEN_W-1:0]  gen_inc;

    logic                       link_we;
    logic [gsa_pkg::LINK_W-1:0] link_wdata;
    logic                       stamp_we;
    logic                       rsp_ok;
    logic [gsa_pkg::IDX_W-1:0]  rsp_idx;
    logic [gsa_pkg::GEN_W-1:0]  rsp_gen;
    logic                       rsp_space;

    assign req_mode = i_req_data[1:0];
    assign req_idx  = i_req_data[11:2];
    assign req_gen  = i_req_data[19:12];
    // allocate reads at the head; an unusable head is ignored later
    assign rd_addr  = (req_mode == gsa_pkg::MODE_ALLOC) ? r_head[gsa_pkg::IDX_W-1:0] : req_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_link_q <= r_link_mem[rd_addr];
        end
        if (link_we) begin
            r_link_mem[r_addr] <= link_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_stamp_q <= r_stamp_mem[rd_addr];
        end
        if (stamp_we) begin
            r_stamp_mem[r_addr] <= gen_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= req_mode;
            r_addr <= req_idx;
            r_gen  <= req_gen;
            if (req_mode == gsa_pkg::MODE_ALLOC) begin
                r_addr <= r_head[gsa_pkg::IDX_W-1:0];
            end
        end
    end

    // entries at or above the fill count were never written: reset contents
    assign slot_ext    = {1'b0, r_addr};
    assign untouched   = slot_ext >= r_fill;
    assign link_val    = untouched ? slot_ext + 11'd1 : r_link_q;
    assign stamp_val   = untouched ? '0 : r_stamp_q;
    assign head_usable = (r_head < r_active) && (r_head < gsa_pkg::SLOTS_END);
    assign handle_ok   = (slot_ext < r_active) && (link_val == slot_ext) && (stamp_val == r_gen);
    assign gen_inc     = r_gen_ctr + 1'b1;

    always_comb begin
        n_head     = r_head;
        n_gen_ctr  = r_gen_ctr;
        n_fill     = r_fill;
        link_we    = 1'b0;
        link_wdata = slot_ext;
        stamp_we   = 1'b0;
        rsp_ok     = 1'b0;
        rsp_idx    = '0;
        rsp_gen    = '0;
        unique case (r_mode)
            gsa_pkg::MODE_ALLOC: begin
                if (head_usable) begin
                    n_head    = link_val;
                    n_gen_ctr = gen_inc;
                    link_we   = i_cmd.exec;
                    stamp_we  = i_cmd.exec;
                    rsp_ok    = 1'b1;
                    rsp_idx   = r_addr;
                    rsp_gen   = gen_inc;
                    if (untouched) begin
                        n_fill = r_fill + 11'd1;
                    end
                end
            end
            gsa_pkg::MODE_FREE: begin
                if (handle_ok) begin
                    n_head     = slot_ext;
                    link_we    = i_cmd.exec;
                    link_wdata = r_head;
                    rsp_ok     = 1'b1;
                end
            end
            gsa_pkg::MODE_CHECK: begin
                rsp_ok = handle_ok;
            end
            default: rsp_ok = 1'b0;
        endcase
        rsp_space = (n_head < r_active) && (n_head < gsa_pkg::SLOTS_END);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_gen_ctr   <= '0;
            r_fill      <= '0;
            r_active    <= gsa_pkg::ACTIVE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_head      <= n_head;
                r_gen_ctr   <= n_gen_ctr;
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_data <= {4'b0, rsp_space, rsp_gen, rsp_idx, rsp_ok};
        end
    end

    assign o_status.out_free = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid       = r_out_valid;
    assign o_rsp_data        = r_out_data;

    `GSA_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= gsa_pkg::SLOTS_END, "fill overrun")
    `GSA_ASSERT_NEXT(a_exec_loads_out, i_clk, i_rst_n, i_cmd.exec, r_out_valid, "result lost")
    `GSA_ASSERT_NEXT(a_gen_stable, i_clk, i_rst_n, !i_cmd.exec, $stable(r_gen_ctr) && $stable(r_head), "state moved")

endmodule
`default_nettype wire

@@ rtl/core/generational_slot_allocator.sv @@
// Generational slot allocator, top level: sequencer plus datapath.
// Sequence: an accepted request has its link/stamp table read registered, then the result register is
//   loaded in the update phase; this is later while an earlier result still waits on o_m_axis_tready.
// Requests: no new request is accepted until the last one has loaded its result, because of the registered
//   read of the link/stamp tables that feeds the head and table update; output stalls hold it off further.
// Reset: synchronous, active low; head, generation and fill count clear, no
//   clearing pass (unwritten table entries read as reset values via fill count).
`timescale 1ns / 1ps
`default_nettype none
module generational_slot_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_wdata,      // active_slots
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // mode[1:0], slot_index[11:2], slot_generation[19:12]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata    // ok[0], given_index[10:1], given_generation[18:11], has_space[19]
);

    gsa_pkg::t_cmd    cmd;
    gsa_pkg::t_status status;

    gsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    gsa_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_req_data  (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp_valid (o_m_axis_tvalid),
        .i_rsp_ready (i_m_axis_tready),
        .o_rsp_data  (o_m_axis_tdata)
    );

endmodule
`default_nettype wire
